// ===== sv/bbba_pkg.sv =====
// Bucketed bitmap block allocator: shared constants, codes and types.
// No dependencies; every other file of the block but bbba_ram imports this package.
package bbba_pkg;

    // Sizing of the block
    localparam int BUCKETS        = 4;
    localparam int BITMAP_BYTES   = 512;
    localparam int MAX_ALIGN_LOG2 = 12;
    localparam int NREGS          = 4;
    localparam int ACT_LIM        = (BUCKETS < NREGS) ? BUCKETS : NREGS;

    // Field widths
    localparam int SIZE_W    = 24;
    localparam int ALOG_W    = 4;
    localparam int BKT_W     = 2;
    localparam int OFS_W     = 28;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int MEM_DEPTH = BUCKETS * BITMAP_BYTES;
    localparam int BYTE_W    = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int BLK_W     = BYTE_W + 3;
    localparam int RNG_W     = BLK_W + 1;
    localparam int NEXT_W    = RNG_W - 2;
    localparam int EXT_W     = $clog2(BITMAP_BYTES + 1);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int AL_W      = MAX_ALIGN_LOG2 + 1;
    localparam int CNT_W     = $clog2(ACT_LIM + 1);
    localparam int NEED_W    = SIZE_W + 1;

    // Block sizes after reset
    localparam logic [CFG_W-1:0] BS_RESET [NREGS] = '{16'd8, 16'd32, 16'd256, 16'd0};

    // Request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_SIZE_ZERO = 2'd1,
        ST_NO_ROOM   = 2'd2,
        ST_IGNORED   = 2'd3
    } res_status_t;

    typedef enum logic [1:0] {
        DIV_SCORE,
        DIV_FREE_OFS,
        DIV_FREE_SIZE,
        DIV_EXT
    } div_sel_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SC_GO,
        S_SC_WAIT,
        S_SCAN_INIT,
        S_SCAN,
        S_EXT,
        S_EXT_WAIT,
        S_EXT_CHK,
        S_FR_WAIT1,
        S_FR_CHK,
        S_FR_WAIT2,
        S_MOD_RD,
        S_MOD_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic        clr_step;
        logic        load;
        logic        div_start;
        div_sel_t    div_sel;
        logic        score_init;
        logic        score_upd;
        logic        scan_init;
        logic        scan_rd;
        logic        ext_calc;
        logic        ext_upd;
        logic        ext_commit;
        logic        free_first;
        logic        free_range;
        logic        mod_rd;
        logic        mod_wr;
        logic        set_res;
        res_status_t res_code;
        logic        emit;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_valid;
        logic is_free;
        logic size_zero;
        logic n_zero;
        logic bin_bad;
        logic div_done;
        logic score_last;
        logic scan_found;
        logic scan_end;
        logic ext_grow;
        logic ext_over;
        logic free_ignore;
        logic mod_last;
        logic out_free;
    } stat_t;

endpackage

// ===== sv/bbba_if.sv =====
// Valid/ready channel interfaces of the block allocator.
// Depends on bbba_pkg for field widths.
interface bbba_req_if import bbba_pkg::*;;
    logic              valid;
    logic              ready;
    logic              command;
    logic [SIZE_W-1:0] size;
    logic [ALOG_W-1:0] align_log2;
    logic [BKT_W-1:0]  bucket;
    logic [OFS_W-1:0]  offset;

    modport source (output valid, command, size, align_log2, bucket, offset, input ready);
    modport sink   (input valid, command, size, align_log2, bucket, offset, output ready);
endinterface

interface bbba_rsp_if import bbba_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BKT_W-1:0]  chosen_bucket;
    logic [OFS_W-1:0]  byte_offset;

    modport source (output valid, status, chosen_bucket, byte_offset, input ready);
    modport sink   (input valid, status, chosen_bucket, byte_offset, output ready);
endinterface

// ===== sv/bbba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/bbba_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on bbba_pkg for operand widths.
module bbba_div import bbba_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OFS_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             done,
    output logic [OFS_W-1:0] quotient,
    output logic [CFG_W-1:0] remainder
);
    localparam int CW = $clog2(OFS_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [OFS_W-1:0] quo_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] dvs_reg;
    logic [CFG_W:0]   trial;
    logic             ge;

    // Shift in the next dividend bit and try a subtraction
    assign trial = {rem_reg, quo_reg[OFS_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(OFS_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? CFG_W'(trial - {1'b0, dvs_reg}) : trial[CFG_W-1:0];
            quo_reg <= {quo_reg[OFS_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ===== sv/bbba_ctrl.sv =====
// Sequencer of the block allocator: steps an alloc through scoring, scan,
// extent growth and bitmap update, a free to the update. Depends on bbba_pkg.
module bbba_ctrl import bbba_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t st,
    output logic  in_ready,
    output cmd_t  cmd
);
    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (st.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (!st.is_free && st.size_zero)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_SIZE_ZERO;
                    state_next   = S_RESULT;
                end
                else if (!st.is_free && st.n_zero)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NO_ROOM;
                    state_next   = S_RESULT;
                end
                else if (!st.is_free)
                begin
                    cmd.score_init = 1'b1;
                    state_next     = S_SC_GO;
                end
                else if (st.bin_bad)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_IGNORED;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_FREE_OFS;
                    state_next    = S_FR_WAIT1;
                end
            end
            S_SC_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SCORE;
                state_next    = S_SC_WAIT;
            end
            S_SC_WAIT:
            begin
                cmd.div_sel = DIV_SCORE;
                if (st.div_done)
                begin
                    cmd.score_upd = 1'b1;
                    state_next    = st.score_last ? S_SCAN_INIT : S_SC_GO;
                end
            end
            S_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (st.scan_found)
                begin
                    state_next = S_EXT;
                end
                else if (st.scan_end)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NO_ROOM;
                    state_next   = S_RESULT;
                end
            end
            S_EXT:
            begin
                cmd.ext_calc = 1'b1;
                cmd.div_sel  = DIV_EXT;
                if (st.ext_grow)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_EXT_WAIT;
                end
                else
                begin
                    state_next = S_EXT_CHK;
                end
            end
            S_EXT_WAIT:
            begin
                cmd.div_sel = DIV_EXT;
                if (st.div_done)
                begin
                    cmd.ext_upd = 1'b1;
                    state_next  = S_EXT_CHK;
                end
            end
            S_EXT_CHK:
            begin
                cmd.set_res = 1'b1;
                if (st.ext_over)
                begin
                    cmd.res_code = ST_NO_ROOM;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.res_code   = ST_OK;
                    cmd.ext_commit = 1'b1;
                    state_next     = S_MOD_RD;
                end
            end
            S_FR_WAIT1:
            begin
                cmd.div_sel = DIV_FREE_OFS;
                if (st.div_done)
                begin
                    cmd.free_first = 1'b1;
                    state_next     = S_FR_CHK;
                end
            end
            S_FR_CHK:
            begin
                priority if (st.free_ignore)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_IGNORED;
                    state_next   = S_RESULT;
                end
                else if (st.size_zero)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_SIZE_ZERO;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_FREE_SIZE;
                    state_next    = S_FR_WAIT2;
                end
            end
            S_FR_WAIT2:
            begin
                cmd.div_sel = DIV_FREE_SIZE;
                if (st.div_done)
                begin
                    cmd.free_range = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_code   = ST_OK;
                    state_next     = S_MOD_RD;
                end
            end
            S_MOD_RD:
            begin
                cmd.mod_rd = 1'b1;
                state_next = S_MOD_WR;
            end
            S_MOD_WR:
            begin
                cmd.mod_wr = 1'b1;
                state_next = st.mod_last ? S_RESULT : S_MOD_RD;
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== sv/bbba_dp.sv =====
// Datapath of the block allocator: configuration, extents, bitmap RAM,
// divider, scan logic and output register. Depends on bbba_pkg, bbba_ram,
// bbba_div.
module bbba_dp import bbba_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                st,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_command,
    input  logic [SIZE_W-1:0]    in_size,
    input  logic [ALOG_W-1:0]    in_align_log2,
    input  logic [BKT_W-1:0]     in_bucket,
    input  logic [OFS_W-1:0]     in_offset,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [STAT_W-1:0]    out_status,
    output logic [BKT_W-1:0]     out_chosen,
    output logic [OFS_W-1:0]     out_boff
);
    // Configuration and extents
    logic [CFG_W-1:0]  bsz_reg [NREGS];
    logic [EXT_W-1:0]  ext_reg [BUCKETS];

    // Item under work
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ALOG_W-1:0] al_reg;
    logic [OFS_W-1:0]  ofs_reg;
    logic [BKT_W-1:0]  wk_bkt_reg;

    // Scoring
    logic [BKT_W-1:0]  idx_reg;
    logic [BKT_W-1:0]  best_reg;
    logic [CFG_W-1:0]  bw_reg;
    logic [NEED_W-1:0] bb_reg;

    // Clearing pass and scan
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [BYTE_W:0]   rd_cnt_reg;
    logic              pend_reg;
    logic [BYTE_W-1:0] pbyte_reg;
    logic [RNG_W-1:0]  run_reg;
    logic [BLK_W-1:0]  s_reg;
    logic [AL_W-1:0]   acc_reg;

    // Extent, free and bitmap update
    logic [NEXT_W-1:0] newext_reg;
    logic [OFS_W-1:0]  boff_tmp_reg;
    logic [OFS_W-1:0]  first_reg;
    logic [RNG_W-1:0]  lo_reg;
    logic [RNG_W-1:0]  hi_reg;
    logic [BYTE_W-1:0] mb_reg;

    // Result and output
    res_status_t       res_status_reg;
    logic [OFS_W-1:0]  res_boff_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [BKT_W-1:0]  out_chosen_reg;
    logic [OFS_W-1:0]  out_boff_reg;

    // Combinational
    logic [CNT_W-1:0]  n_act;
    logic              n_stop;
    logic [CFG_W-1:0]  bsw;
    logic [CFG_W-1:0]  bsi;
    logic [EXT_W-1:0]  ext_w;
    logic [AL_W-1:0]   amask;
    logic              div_start;
    logic [OFS_W-1:0]  div_dvd;
    logic [CFG_W-1:0]  div_dvs;
    logic              div_done;
    logic [OFS_W-1:0]  div_q;
    logic [CFG_W-1:0]  div_r;
    logic [NEED_W-1:0] blocks_c;
    logic [CFG_W-1:0]  waste_c;
    logic              better_c;
    logic              proc;
    logic [RNG_W-1:0]  run_c;
    logic [BLK_W-1:0]  s_c;
    logic [AL_W-1:0]   acc_c;
    logic              fnd_c;
    logic [RNG_W-1:0]  need_s;
    logic [RNG_W:0]    req_sum;
    logic [RNG_W:0]    g_sum;
    logic [NEXT_W-1:0] req_c;
    logic [NEXT_W-1:0] g_c;
    logic [NEXT_W:0]   edv_c;
    logic [NEXT_W:0]   kg_c;
    logic [RNG_W-1:0]  limit_c;
    logic [RNG_W-1:0]  room_c;
    logic [7:0]        mask_c;
    logic [RNG_W-1:0]  ib_m;
    logic              rd_issue;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              we;
    logic [7:0]        wdata;
    logic [7:0]        rdata;

    // Active buckets: those before the first zero block size
    always_comb
    begin
        n_act  = '0;
        n_stop = 1'b0;
        for (int k = 0; k < ACT_LIM; k++)
        begin
            if (!n_stop && bsz_reg[k] != '0)
            begin
                n_act = n_act + 1'b1;
            end
            else
            begin
                n_stop = 1'b1;
            end
        end
    end

    assign bsw   = bsz_reg[wk_bkt_reg];
    assign bsi   = bsz_reg[idx_reg];
    assign ext_w = ext_reg[wk_bkt_reg];
    assign amask = ~({AL_W{1'b1}} << al_reg);

    // Divider operand selection
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SCORE:
            begin
                div_dvd = OFS_W'(size_reg);
                div_dvs = bsi;
            end
            DIV_FREE_OFS:
            begin
                div_dvd = ofs_reg;
                div_dvs = bsw;
            end
            DIV_FREE_SIZE:
            begin
                div_dvd = OFS_W'(size_reg);
                div_dvs = bsw;
            end
            default:
            begin
                div_dvd = OFS_W'(edv_c);
                div_dvs = CFG_W'(g_c);
            end
        endcase
    end

    assign div_start = cmd.div_start;

    bbba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Blocks and wasted bytes from the quotient and remainder
    assign blocks_c = NEED_W'(div_q) + NEED_W'(div_r != '0);
    assign waste_c  = (div_r == '0) ? '0 : CFG_W'(bsi - div_r);
    assign better_c = (idx_reg == '0) || (waste_c < bw_reg)
                      || ((waste_c == bw_reg) && (blocks_c < bb_reg));

    // Walk the eight blocks of one bitmap byte
    assign proc = cmd.scan_rd && pend_reg;
    always_comb
    begin
        run_c = run_reg;
        s_c   = s_reg;
        acc_c = acc_reg;
        fnd_c = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            if (!fnd_c)
            begin
                if (rdata[j])
                begin
                    run_c = '0;
                end
                else if (run_c == '0)
                begin
                    if ((acc_c & amask) == '0)
                    begin
                        s_c   = {pbyte_reg, 3'(j)};
                        run_c = RNG_W'(1);
                    end
                end
                else
                begin
                    run_c = run_c + 1'b1;
                end
                if (run_c != '0 && NEED_W'(run_c) == bb_reg)
                begin
                    fnd_c = 1'b1;
                end
                acc_c = acc_c + AL_W'(bsw);
            end
        end
    end

    // Extent growth
    assign need_s  = RNG_W'(bb_reg);
    assign req_sum = (RNG_W+1)'(s_reg) + (RNG_W+1)'(need_s) + (RNG_W+1)'(7);
    assign g_sum   = (RNG_W+1)'(need_s) + (RNG_W+1)'(7);
    assign req_c   = req_sum[RNG_W:3];
    assign g_c     = g_sum[RNG_W:3];
    assign edv_c   = (NEXT_W+1)'(req_c) - (NEXT_W+1)'(ext_w) + (NEXT_W+1)'(g_c)
                     - (NEXT_W+1)'(1);
    assign kg_c    = edv_c - (NEXT_W+1)'(div_r);

    // Free range
    assign limit_c = RNG_W'({ext_w, 3'b000});
    assign room_c  = limit_c - RNG_W'(first_reg);

    // Byte mask of blocks in the range being set or cleared
    always_comb
    begin
        mask_c = '0;
        ib_m   = '0;
        for (int j = 0; j < 8; j++)
        begin
            ib_m      = RNG_W'({mb_reg, 3'(j)});
            mask_c[j] = (ib_m >= lo_reg) && (ib_m < hi_reg);
        end
    end

    // Bitmap RAM ports
    assign rd_issue  = cmd.scan_rd && (rd_cnt_reg < (BYTE_W+1)'(BITMAP_BYTES));
    assign base_addr = ADDR_W'(wk_bkt_reg) * ADDR_W'(BITMAP_BYTES);
    assign raddr     = cmd.mod_rd ? base_addr + ADDR_W'(mb_reg)
                                  : base_addr + ADDR_W'(rd_cnt_reg[BYTE_W-1:0]);
    assign we        = cmd.clr_step || cmd.mod_wr;
    assign waddr     = cmd.clr_step ? clr_cnt_reg : base_addr + ADDR_W'(mb_reg);
    assign wdata     = cmd.clr_step ? 8'h00
                     : (op_reg == CMD_FREE) ? (rdata & ~mask_c) : (rdata | mask_c);

    bbba_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Configuration and extents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NREGS; k++)
            begin
                bsz_reg[k] <= BS_RESET[k];
            end
            for (int k = 0; k < BUCKETS; k++)
            begin
                ext_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bsz_reg[cfg_index] <= cfg_data;
            end
            if (cmd.ext_commit)
            begin
                ext_reg[wk_bkt_reg] <= EXT_W'(newext_reg);
            end
        end
    end

    // Control counters and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            pend_reg <= rd_issue;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= in_command;
            size_reg     <= in_size;
            ofs_reg      <= in_offset;
            al_reg       <= ((ALOG_W+1)'(in_align_log2) > (ALOG_W+1)'(MAX_ALIGN_LOG2))
                            ? ALOG_W'(MAX_ALIGN_LOG2) : in_align_log2;
            wk_bkt_reg   <= (in_command == CMD_FREE) ? in_bucket : '0;
            res_boff_reg <= '0;
        end
        if (cmd.score_init)
        begin
            idx_reg <= '0;
        end
        if (cmd.score_upd)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (better_c)
            begin
                best_reg <= idx_reg;
                bw_reg   <= waste_c;
                bb_reg   <= blocks_c;
            end
        end
        if (cmd.scan_init)
        begin
            wk_bkt_reg <= best_reg;
            rd_cnt_reg <= '0;
            pbyte_reg  <= '0;
            run_reg    <= '0;
            s_reg      <= '0;
            acc_reg    <= '0;
        end
        if (rd_issue)
        begin
            rd_cnt_reg <= rd_cnt_reg + 1'b1;
        end
        if (proc)
        begin
            run_reg   <= run_c;
            s_reg     <= s_c;
            acc_reg   <= acc_c;
            pbyte_reg <= pbyte_reg + 1'b1;
        end
        if (cmd.ext_calc)
        begin
            newext_reg   <= NEXT_W'(ext_w);
            boff_tmp_reg <= OFS_W'(OFS_W'(s_reg) * OFS_W'(bsw));
        end
        if (cmd.ext_upd)
        begin
            newext_reg <= NEXT_W'((NEXT_W+1)'(ext_w) + kg_c);
        end
        if (cmd.ext_commit)
        begin
            lo_reg       <= RNG_W'(s_reg);
            hi_reg       <= RNG_W'(s_reg) + need_s;
            mb_reg       <= s_reg[BLK_W-1:3];
            res_boff_reg <= boff_tmp_reg;
        end
        if (cmd.free_first)
        begin
            first_reg    <= div_q;
            boff_tmp_reg <= ofs_reg - OFS_W'(div_r);
        end
        if (cmd.free_range)
        begin
            lo_reg       <= RNG_W'(first_reg);
            hi_reg       <= (blocks_c >= NEED_W'(room_c)) ? limit_c
                            : RNG_W'(first_reg) + RNG_W'(blocks_c);
            mb_reg       <= first_reg[BLK_W-1:3];
            res_boff_reg <= boff_tmp_reg;
        end
        if (cmd.mod_wr)
        begin
            mb_reg <= mb_reg + 1'b1;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_code;
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_chosen_reg <= wk_bkt_reg;
            out_boff_reg   <= res_boff_reg;
        end
    end

    // Status towards the sequencer
    always_comb
    begin
        st.clr_done    = clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1);
        st.in_valid    = in_valid;
        st.is_free     = op_reg == CMD_FREE;
        st.size_zero   = size_reg == '0;
        st.n_zero      = n_act == '0;
        st.bin_bad     = CNT_W'(wk_bkt_reg) >= n_act;
        st.div_done    = div_done;
        st.score_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == n_act;
        st.scan_found  = proc && fnd_c;
        st.scan_end    = proc && !fnd_c && (pbyte_reg == BYTE_W'(BITMAP_BYTES - 1));
        st.ext_grow    = (NEXT_W+1)'(req_c) > (NEXT_W+1)'(ext_w);
        st.ext_over    = (NEXT_W+1)'(newext_reg) > (NEXT_W+1)'(BITMAP_BYTES);
        st.free_ignore = first_reg >= OFS_W'(limit_c);
        st.mod_last    = ((RNG_W+1)'({mb_reg, 3'b000}) + (RNG_W+1)'(8))
                         >= (RNG_W+1)'(hi_reg);
        st.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_chosen = out_chosen_reg;
    assign out_boff   = out_boff_reg;
endmodule

// ===== sv/bucketed_bitmap_block_allocator_unit.sv =====
// Top level of the bucketed bitmap block allocator.
// Depends on bbba_pkg, bbba_if, bbba_ctrl and bbba_dp.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+------------------------------------------
//  request   | in  | valid / ready | command, size, align_log2, bucket, offset
//  result    | out | valid / ready | status, chosen_bucket, byte_offset
//  cfg       | in  | cfg_wr_en     | cfg_index, cfg_data
//
// After reset a clearing pass writes zero to all 2048 bitmap bytes, one a
// cycle, and no item is taken until that pass is done.
// An allocation scores each active bucket on the shared divider, scans up to
// 512 bitmap bytes, may grow the extent with one more division and then sets
// its blocks by reading and writing each byte; a free divides twice and clears.
// One item at a time; a result waits in the output register without stalling
// the next item's work until it is itself ready to be shown.
module bucketed_bitmap_block_allocator_unit import bbba_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    bbba_req_if.sink             request,
    bbba_rsp_if.source           result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    cmd_t  cmd;
    stat_t st;
    logic  in_ready;

    // Sequencer
    bbba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Datapath
    bbba_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (request.valid),
        .in_command    (request.command),
        .in_size       (request.size),
        .in_align_log2 (request.align_log2),
        .in_bucket     (request.bucket),
        .in_offset     (request.offset),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .out_status    (result.status),
        .out_chosen    (result.chosen_bucket),
        .out_boff      (result.byte_offset)
    );

    assign request.ready = in_ready;
endmodule
